@@ rtl/spdd_pkg.sv @@
// Shared types and constants for the servo pulse decoder with dead-zone snapping.
// No dependencies; used by every module in rtl/.
package spdd_pkg;

    localparam int W_WIDTH    = 15;
    localparam int W_IDLE     = 20;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 20;

    localparam logic [W_WIDTH-1:0] WIDTH_MAX = {W_WIDTH{1'b1}};
    localparam logic [W_IDLE-1:0]  IDLE_MAX  = {W_IDLE{1'b1}};

    // Snap target defaults in ticks.
    localparam int MID_SNAP_DEF = 1500;
    localparam int MIN_SNAP_DEF = 1000;
    localparam int MAX_SNAP_DEF = 2000;

    // Register indexes of the configuration port.
    localparam logic [W_CFG_IDX-1:0] CFG_TIMEOUT_TICKS   = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_END_SNAP_EN     = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_MID_SNAP_EN     = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_MID_WINDOW_LOW  = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_MID_WINDOW_HIGH = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_LOW_END_THRESH  = 3'd5;
    localparam logic [W_CFG_IDX-1:0] CFG_HIGH_END_THRESH = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [W_IDLE-1:0]  TIMEOUT_TICKS_RST   = 20'd25000;
    localparam logic [W_WIDTH-1:0] MID_WINDOW_LOW_RST  = 15'd1480;
    localparam logic [W_WIDTH-1:0] MID_WINDOW_HIGH_RST = 15'd1520;
    localparam logic [W_WIDTH-1:0] LOW_END_THRESH_RST  = 15'd1020;
    localparam logic [W_WIDTH-1:0] HIGH_END_THRESH_RST = 15'd1980;

    typedef struct packed {
        logic               end_snap_en;
        logic               mid_snap_en;
        logic [W_WIDTH-1:0] mid_window_low;
        logic [W_WIDTH-1:0] mid_window_high;
        logic [W_WIDTH-1:0] low_end_thresh;
        logic [W_WIDTH-1:0] high_end_thresh;
    } t_spdd_snap_cfg;

    // Raw result of the edge tracker before snapping.
    typedef struct packed {
        logic               valid;
        logic               timed_out;
        logic [W_WIDTH-1:0] width;
    } t_spdd_raw;

    // Tracker status seen by the top level.
    typedef struct packed {
        logic measuring;
        logic level_known;
    } t_spdd_status;

endpackage

@@ rtl/servo_pulse_decoder_deadzone_unit.sv @@
// Top level of the servo pulse decoder with dead-zone snapping.
// Depends on spdd_pkg, spdd_track and spdd_snap.
//
// Usage: feed one sampled servo line level per microsecond tick as a word on
// the input channel (i_in_valid / o_in_stall / i_in_pin_level). A rising edge
// after a low starts a measurement, and the first low sample after it makes a
// result word on the output channel (o_out_valid / i_out_stall) carrying the
// snapped width. If the line holds still for timeout_ticks samples while the
// block waits for a pulse, a result word with o_out_timed_out set and a width
// of zero is produced. Most samples produce no result word.
// Timing: an accepted sample lands in the input register; its result, if any,
// is loaded into the output register when the single tracker stage between
// them next advances. Throughput: one sample per cycle while not stalled.
// Stall: while the output register holds an untaken word and i_out_stall is
// high, the tracker stage holds and o_in_stall rises once the input register
// is full; nothing is dropped. Reset (synchronous, active low) empties both
// registers, clears the tracker and loads the default configuration.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// idle; the user must keep to this, the block itself does not enforce it.
module servo_pulse_decoder_deadzone_unit #(
    parameter int MID_SNAP = spdd_pkg::MID_SNAP_DEF,
    parameter int MIN_SNAP = spdd_pkg::MIN_SNAP_DEF,
    parameter int MAX_SNAP = spdd_pkg::MAX_SNAP_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_in_pin_level,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [spdd_pkg::W_WIDTH-1:0]         o_out_pulse_width,
    output logic                                 o_out_timed_out,
    input  logic                                 i_cfg_we,
    input  logic [spdd_pkg::W_CFG_IDX-1:0]       i_cfg_idx,
    input  logic [spdd_pkg::W_CFG_DATA-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [spdd_pkg::W_IDLE-1:0]  r_timeout_ticks;
    spdd_pkg::t_spdd_snap_cfg     r_snap_cfg;

    // Input register.
    logic r_in_valid;
    logic r_in_level;

    // Output register.
    logic                         r_out_valid;
    logic [spdd_pkg::W_WIDTH-1:0] r_out_width;
    logic                         r_out_timed_out;

    logic                         advance;
    logic                         in_accept;
    logic                         stage_en;
    spdd_pkg::t_spdd_raw          raw;
    spdd_pkg::t_spdd_status       status;
    logic [spdd_pkg::W_WIDTH-1:0] snapped;
    logic [spdd_pkg::W_WIDTH-1:0] n_out_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks            <= spdd_pkg::TIMEOUT_TICKS_RST;
            r_snap_cfg.end_snap_en     <= 1'b0;
            r_snap_cfg.mid_snap_en     <= 1'b0;
            r_snap_cfg.mid_window_low  <= spdd_pkg::MID_WINDOW_LOW_RST;
            r_snap_cfg.mid_window_high <= spdd_pkg::MID_WINDOW_HIGH_RST;
            r_snap_cfg.low_end_thresh  <= spdd_pkg::LOW_END_THRESH_RST;
            r_snap_cfg.high_end_thresh <= spdd_pkg::HIGH_END_THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spdd_pkg::CFG_TIMEOUT_TICKS: begin
                    r_timeout_ticks <= i_cfg_data;
                end
                spdd_pkg::CFG_END_SNAP_EN: begin
                    r_snap_cfg.end_snap_en <= i_cfg_data[0];
                end
                spdd_pkg::CFG_MID_SNAP_EN: begin
                    r_snap_cfg.mid_snap_en <= i_cfg_data[0];
                end
                spdd_pkg::CFG_MID_WINDOW_LOW: begin
                    r_snap_cfg.mid_window_low <= i_cfg_data[spdd_pkg::W_WIDTH-1:0];
                end
                spdd_pkg::CFG_MID_WINDOW_HIGH: begin
                    r_snap_cfg.mid_window_high <= i_cfg_data[spdd_pkg::W_WIDTH-1:0];
                end
                spdd_pkg::CFG_LOW_END_THRESH: begin
                    r_snap_cfg.low_end_thresh <= i_cfg_data[spdd_pkg::W_WIDTH-1:0];
                end
                spdd_pkg::CFG_HIGH_END_THRESH: begin
                    r_snap_cfg.high_end_thresh <= i_cfg_data[spdd_pkg::W_WIDTH-1:0];
                end
                default: begin
                    // Writes to unused indexes are ignored.
                end
            endcase
        end
    end

    // The tracker stage moves whenever the output register can take a word.
    assign advance    = !r_out_valid || !i_out_stall;
    assign stage_en   = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_level <= i_in_pin_level;
        end
    end

    spdd_track u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (stage_en),
        .i_level         (r_in_level),
        .i_timeout_ticks (r_timeout_ticks),
        .o_raw           (raw),
        .o_status        (status)
    );

    spdd_snap #(
        .MID_SNAP (MID_SNAP),
        .MIN_SNAP (MIN_SNAP),
        .MAX_SNAP (MAX_SNAP)
    ) u_snap (
        .i_cfg   (r_snap_cfg),
        .i_width (raw.width),
        .o_width (snapped)
    );

    // A timeout always reports a width of zero, never a snapped value.
    assign n_out_width = raw.timed_out ? '0 : snapped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= raw.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && raw.valid) begin
            r_out_width     <= n_out_width;
            r_out_timed_out <= raw.timed_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_pulse_width = r_out_width;
    assign o_out_timed_out   = r_out_timed_out;

    // A timeout word always carries a zero width.
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_timed_out) |-> (o_out_pulse_width == '0))
        else $error("timeout result with nonzero width");

    // The input side only stalls while the input register is occupied.
    a_stall_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with empty input register");

    // A result leaves the tracker fully rearmed.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        raw.valid |=> (!status.measuring && !status.level_known))
        else $error("tracker not rearmed after result");

    // A measurement can only end in a width result, never a timeout.
    a_measure_no_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.measuring && raw.valid) |-> !raw.timed_out)
        else $error("timeout raised during measurement");

endmodule

@@ rtl/spdd_track.sv @@
// Edge tracker: level history, high-tick counter and idle timeout.
// Depends on spdd_pkg.
module spdd_track (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_level,
    input  logic [spdd_pkg::W_IDLE-1:0]         i_timeout_ticks,
    output spdd_pkg::t_spdd_raw                 o_raw,
    output spdd_pkg::t_spdd_status              o_status
);

    logic                              r_last_level, n_last_level;
    logic                              r_level_known, n_level_known;
    logic                              r_seen_low, n_seen_low;
    logic                              r_measuring, n_measuring;
    logic [spdd_pkg::W_IDLE-1:0]       r_idle_count, n_idle_count;
    logic [spdd_pkg::W_WIDTH-1:0]      r_high_count, n_high_count;
    logic [spdd_pkg::W_IDLE-1:0]       idle_inc;
    logic                              rearm;

    always_comb begin
        n_last_level  = r_last_level;
        n_level_known = r_level_known;
        n_seen_low    = r_seen_low;
        n_measuring   = r_measuring;
        n_idle_count  = r_idle_count;
        n_high_count  = r_high_count;
        rearm         = 1'b0;
        o_raw         = '0;
        idle_inc      = (r_idle_count != spdd_pkg::IDLE_MAX) ?
                        r_idle_count + 1'b1 : r_idle_count;

        if (r_measuring) begin
            if (i_level) begin
                if (r_high_count != spdd_pkg::WIDTH_MAX) begin
                    n_high_count = r_high_count + 1'b1;
                end
            end else begin
                o_raw.valid = 1'b1;
                o_raw.width = r_high_count;
                rearm       = 1'b1;
            end
        end else if (!r_level_known || (i_level != r_last_level)) begin
            n_idle_count  = '0;
            n_last_level  = i_level;
            n_level_known = 1'b1;
            if (!i_level) begin
                n_seen_low = 1'b1;
            end else if (r_seen_low) begin
                n_measuring  = 1'b1;
                n_high_count = spdd_pkg::W_WIDTH'(1);
            end
        end else begin
            n_idle_count = idle_inc;
            if (idle_inc >= i_timeout_ticks) begin
                o_raw.valid     = 1'b1;
                o_raw.timed_out = 1'b1;
                rearm           = 1'b1;
            end
        end

        // Every result returns the tracker to its reset state.
        if (rearm) begin
            n_last_level  = 1'b0;
            n_level_known = 1'b0;
            n_seen_low    = 1'b0;
            n_measuring   = 1'b0;
            n_idle_count  = '0;
            n_high_count  = '0;
        end

        if (!i_en) begin
            o_raw.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level  <= 1'b0;
            r_level_known <= 1'b0;
            r_seen_low    <= 1'b0;
            r_measuring   <= 1'b0;
            r_idle_count  <= '0;
            r_high_count  <= '0;
        end else if (i_en) begin
            r_last_level  <= n_last_level;
            r_level_known <= n_level_known;
            r_seen_low    <= n_seen_low;
            r_measuring   <= n_measuring;
            r_idle_count  <= n_idle_count;
            r_high_count  <= n_high_count;
        end
    end

    assign o_status.measuring   = r_measuring;
    assign o_status.level_known = r_level_known;

endmodule

@@ rtl/spdd_snap.sv @@
// Dead-zone snapping of a measured width to center or end values.
// Depends on spdd_pkg.
module spdd_snap #(
    parameter int MID_SNAP = spdd_pkg::MID_SNAP_DEF,
    parameter int MIN_SNAP = spdd_pkg::MIN_SNAP_DEF,
    parameter int MAX_SNAP = spdd_pkg::MAX_SNAP_DEF
) (
    input  spdd_pkg::t_spdd_snap_cfg       i_cfg,
    input  logic [spdd_pkg::W_WIDTH-1:0]   i_width,
    output logic [spdd_pkg::W_WIDTH-1:0]   o_width
);

    localparam logic [spdd_pkg::W_WIDTH-1:0] MID_V = spdd_pkg::W_WIDTH'(MID_SNAP);
    localparam logic [spdd_pkg::W_WIDTH-1:0] MIN_V = spdd_pkg::W_WIDTH'(MIN_SNAP);
    localparam logic [spdd_pkg::W_WIDTH-1:0] MAX_V = spdd_pkg::W_WIDTH'(MAX_SNAP);

    logic [spdd_pkg::W_WIDTH-1:0] hi_snapped;

    always_comb begin
        // The low-end test looks at the value after the high-end test.
        hi_snapped = (i_width > i_cfg.high_end_thresh) ? MAX_V : i_width;
        if (i_cfg.mid_snap_en && (i_width < i_cfg.mid_window_high) &&
            (i_width > i_cfg.mid_window_low)) begin
            o_width = MID_V;
        end else if (i_cfg.end_snap_en) begin
            o_width = (hi_snapped < i_cfg.low_end_thresh) ? MIN_V : hi_snapped;
        end else begin
            o_width = i_width;
        end
    end

endmodule

@@ tb/pulse_width_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the servo pulse decoder: follows the register port, predicts
// any result word of each accepted pin sample and compares the words that leave.
// Depends on spdd_pkg only.
module pulse_width_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_in_pin_level,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [spdd_pkg::W_WIDTH-1:0]    i_out_pulse_width,
    input  logic                            i_out_timed_out,
    input  logic                            i_cfg_we,
    input  logic [spdd_pkg::W_CFG_IDX-1:0]  i_cfg_idx,
    input  logic [spdd_pkg::W_CFG_DATA-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_width_words,
    output int                              o_timeout_words
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [spdd_pkg::W_WIDTH-1:0] CENTER_WIDTH =
        spdd_pkg::W_WIDTH'(spdd_pkg::MID_SNAP_DEF);
    localparam logic [spdd_pkg::W_WIDTH-1:0] LOW_END_WIDTH =
        spdd_pkg::W_WIDTH'(spdd_pkg::MIN_SNAP_DEF);
    localparam logic [spdd_pkg::W_WIDTH-1:0] HIGH_END_WIDTH =
        spdd_pkg::W_WIDTH'(spdd_pkg::MAX_SNAP_DEF);

    typedef struct packed {
        logic                         timed_out;
        logic [spdd_pkg::W_WIDTH-1:0] width;
    } t_decoded_word;

    t_decoded_word expected_words[$];

    // Register copies.
    logic [spdd_pkg::W_IDLE-1:0]  timeout_ticks;
    logic                         end_snap_en;
    logic                         mid_snap_en;
    logic [spdd_pkg::W_WIDTH-1:0] window_low;
    logic [spdd_pkg::W_WIDTH-1:0] window_high;
    logic [spdd_pkg::W_WIDTH-1:0] low_end_thresh;
    logic [spdd_pkg::W_WIDTH-1:0] high_end_thresh;

    // Edge tracker state.
    logic                         last_level;
    logic                         level_known;
    logic                         seen_low;
    logic                         measuring;
    logic [spdd_pkg::W_IDLE-1:0]  idle_count;
    logic [spdd_pkg::W_WIDTH-1:0] high_count;

    int fail_count = 0;
    int queued_words = 0;
    int width_words = 0;
    int timeout_words = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = queued_words;
    assign o_width_words   = width_words;
    assign o_timeout_words = timeout_words;

    task automatic clear_tracker();
        last_level  = 1'b0;
        level_known = 1'b0;
        seen_low    = 1'b0;
        measuring   = 1'b0;
        idle_count  = '0;
        high_count  = '0;
    endtask

    // The center window wins; end snapping then tests the upper threshold and
    // afterwards the lower one on the possibly replaced value.
    function automatic logic [spdd_pkg::W_WIDTH-1:0] snapped_width(
        input logic [spdd_pkg::W_WIDTH-1:0] raw);
        logic [spdd_pkg::W_WIDTH-1:0] w;
        w = raw;
        if (mid_snap_en && w > window_low && w < window_high) begin
            return CENTER_WIDTH;
        end
        if (end_snap_en) begin
            if (w > high_end_thresh) begin
                w = HIGH_END_WIDTH;
            end
            if (w < low_end_thresh) begin
                w = LOW_END_WIDTH;
            end
        end
        return w;
    endfunction

    task automatic track_sample(input logic lvl);
        t_decoded_word w;
        if (measuring) begin
            if (lvl) begin
                if (high_count != spdd_pkg::WIDTH_MAX) begin
                    high_count = high_count + 1'b1;
                end
            end else begin
                w.timed_out = 1'b0;
                w.width     = snapped_width(high_count);
                expected_words.push_back(w);
                clear_tracker();
            end
        end else if (!level_known || lvl != last_level) begin
            idle_count  = '0;
            last_level  = lvl;
            level_known = 1'b1;
            if (!lvl) begin
                seen_low = 1'b1;
            end else if (seen_low) begin
                measuring  = 1'b1;
                high_count = spdd_pkg::W_WIDTH'(1);
            end
        end else begin
            if (idle_count != spdd_pkg::IDLE_MAX) begin
                idle_count = idle_count + 1'b1;
            end
            if (idle_count >= timeout_ticks) begin
                w.timed_out = 1'b1;
                w.width     = '0;
                expected_words.push_back(w);
                clear_tracker();
            end
        end
    endtask

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_decoded_word head;
        if (!i_rst_n) begin
            timeout_ticks   = spdd_pkg::TIMEOUT_TICKS_RST;
            end_snap_en     = 1'b0;
            mid_snap_en     = 1'b0;
            window_low      = spdd_pkg::MID_WINDOW_LOW_RST;
            window_high     = spdd_pkg::MID_WINDOW_HIGH_RST;
            low_end_thresh  = spdd_pkg::LOW_END_THRESH_RST;
            high_end_thresh = spdd_pkg::HIGH_END_THRESH_RST;
            clear_tracker();
            expected_words.delete();
        end else begin
            // Compare before predicting, so a word leaving at this edge is never
            // matched against a sample taken at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    flag_error($sformatf("unexpected word width=%0d timed_out=%0b",
                                         i_out_pulse_width, i_out_timed_out));
                end else begin
                    head = expected_words.pop_front();
                    if (head.timed_out) begin
                        timeout_words++;
                    end else begin
                        width_words++;
                    end
                    if (i_out_pulse_width !== head.width) begin
                        flag_error($sformatf("pulse_width expected %0d got %0d",
                                             head.width, i_out_pulse_width));
                    end
                    if (i_out_timed_out !== head.timed_out) begin
                        flag_error($sformatf("timed_out expected %0b got %0b",
                                             head.timed_out, i_out_timed_out));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    spdd_pkg::CFG_TIMEOUT_TICKS:
                        timeout_ticks = i_cfg_data[spdd_pkg::W_IDLE-1:0];
                    spdd_pkg::CFG_END_SNAP_EN:
                        end_snap_en = i_cfg_data[0];
                    spdd_pkg::CFG_MID_SNAP_EN:
                        mid_snap_en = i_cfg_data[0];
                    spdd_pkg::CFG_MID_WINDOW_LOW:
                        window_low = i_cfg_data[spdd_pkg::W_WIDTH-1:0];
                    spdd_pkg::CFG_MID_WINDOW_HIGH:
                        window_high = i_cfg_data[spdd_pkg::W_WIDTH-1:0];
                    spdd_pkg::CFG_LOW_END_THRESH:
                        low_end_thresh = i_cfg_data[spdd_pkg::W_WIDTH-1:0];
                    spdd_pkg::CFG_HIGH_END_THRESH:
                        high_end_thresh = i_cfg_data[spdd_pkg::W_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                track_sample(i_in_pin_level);
            end
        end
        queued_words <= expected_words.size();
    end

endmodule

@@ tb/servo_pulse_decoder_deadzone_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for servo_pulse_decoder_deadzone_unit: clock, reset, pin sample
// stimulus, register writes, receiver stalls and the verdict.
// Depends on spdd_pkg, the block under test and pulse_width_checker.
module servo_pulse_decoder_deadzone_unit_tb;

    // Cycles allowed after the last expected word before the block counts as
    // idle. A sample sits only in the input and output registers, so this is plenty.
    localparam int SETTLE_CYCLES = 6;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_OFF_CYCLES = 400;
    // Random samples per idling phase and per register setting.
    localparam int PHASE_WORDS = 360;
    localparam int ROUND_WORDS = 90;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            pin_level = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [spdd_pkg::W_WIDTH-1:0]    out_pulse_width;
    logic                            out_timed_out;
    logic                            cfg_we = 1'b0;
    logic [spdd_pkg::W_CFG_IDX-1:0]  cfg_idx = '0;
    logic [spdd_pkg::W_CFG_DATA-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int width_words;
    int timeout_words;

    // Percentages of cycles on which each side idles, set per phase.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    int words_sent = 0;
    int settings_used = 0;

    // A hold-off is requested by bumping hold_requests; the stall process
    // notices the difference and counts the stretch down on its own.
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    servo_pulse_decoder_deadzone_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_in_pin_level    (pin_level),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_out_pulse_width (out_pulse_width),
        .o_out_timed_out   (out_timed_out),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data)
    );

    pulse_width_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_in_pin_level    (pin_level),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_out_pulse_width (out_pulse_width),
        .i_out_timed_out   (out_timed_out),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_width_words     (width_words),
        .o_timeout_words   (timeout_words)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver side. Outside a hold-off it stalls at random at the phase rate.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            out_stall    <= 1'b1;
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_OFF_CYCLES;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Offers one pin sample and returns at the edge that accepts it. Valid stays
    // high afterwards, so back-to-back words need no extra step. While idling the
    // pin value wanders, which the block must ignore.
    task automatic send_level(input logic lvl);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid  <= 1'b0;
            pin_level <= 1'($urandom_range(1));
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= lvl;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic send_run(input logic lvl, input int count);
        repeat (count) begin
            send_level(lvl);
        end
    endtask

    // A low stretch, a high stretch of the given width, and the falling edge
    // that closes the measurement.
    task automatic send_pulse(input int low_ticks, input int high_ticks);
        send_run(1'b0, low_ticks);
        send_run(1'b1, high_ticks);
        send_level(1'b0);
    endtask

    // Drops valid and waits until every predicted word has come back, then lets
    // the pipeline settle, since samples that make no word may still be inside.
    task automatic pause_sender();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) begin
            @(posedge clk);
        end
    endtask

    // Leaves the write enable high; program_regs lowers it after the last write.
    task automatic write_reg(input logic [spdd_pkg::W_CFG_IDX-1:0] idx,
                             input logic [spdd_pkg::W_CFG_DATA-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Writes the whole register set; only called while the block is idle.
    task automatic program_regs(input logic [spdd_pkg::W_IDLE-1:0] timeout_ticks,
                                input logic end_en, input logic mid_en,
                                input logic [spdd_pkg::W_WIDTH-1:0] win_low,
                                input logic [spdd_pkg::W_WIDTH-1:0] win_high,
                                input logic [spdd_pkg::W_WIDTH-1:0] low_thresh,
                                input logic [spdd_pkg::W_WIDTH-1:0] high_thresh);
        write_reg(spdd_pkg::CFG_TIMEOUT_TICKS, spdd_pkg::W_CFG_DATA'(timeout_ticks));
        write_reg(spdd_pkg::CFG_END_SNAP_EN, spdd_pkg::W_CFG_DATA'(end_en));
        write_reg(spdd_pkg::CFG_MID_SNAP_EN, spdd_pkg::W_CFG_DATA'(mid_en));
        write_reg(spdd_pkg::CFG_MID_WINDOW_LOW, spdd_pkg::W_CFG_DATA'(win_low));
        write_reg(spdd_pkg::CFG_MID_WINDOW_HIGH, spdd_pkg::W_CFG_DATA'(win_high));
        write_reg(spdd_pkg::CFG_LOW_END_THRESH, spdd_pkg::W_CFG_DATA'(low_thresh));
        write_reg(spdd_pkg::CFG_HIGH_END_THRESH, spdd_pkg::W_CFG_DATA'(high_thresh));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Window bounds and thresholds mostly stay near the pulse widths in use so
    // that every snap rule fires; now and then one lands anywhere in range.
    function automatic logic [spdd_pkg::W_WIDTH-1:0] draw_bound(input int span);
        if ($urandom_range(7) == 0) begin
            return spdd_pkg::W_WIDTH'($urandom_range(0, spdd_pkg::WIDTH_MAX));
        end
        return spdd_pkg::W_WIDTH'($urandom_range(0, span));
    endfunction

    // One register setting followed by random traffic. Most of it is complete
    // pulses with random lengths, the rest flat stretches and loose noise.
    task automatic random_round(input int n_words, input bit with_hold);
        int first;
        int span;
        int pick;
        logic [spdd_pkg::W_IDLE-1:0] tmo;
        first = words_sent;
        span  = $urandom_range(4, 40);
        if ($urandom_range(99) < 80) begin
            tmo = spdd_pkg::W_IDLE'($urandom_range(1, 24));
        end else begin
            tmo = spdd_pkg::W_IDLE'($urandom_range(1000, spdd_pkg::IDLE_MAX));
        end
        pause_sender();
        program_regs(tmo, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     draw_bound(span), draw_bound(span), draw_bound(span),
                     draw_bound(span));
        if (with_hold) begin
            hold_requests <= hold_requests + 1;
        end
        while (words_sent - first < n_words) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_pulse($urandom_range(1, 6), $urandom_range(1, span + 4));
            end else if (pick < 90) begin
                send_run(1'($urandom_range(1)), $urandom_range(1, 30));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_level(1'($urandom_range(1)));
                end
            end
        end
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input bit with_hold);
        int first;
        first = words_sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        random_round(ROUND_WORDS, with_hold);
        while (words_sent - first < PHASE_WORDS) begin
            random_round(ROUND_WORDS, 1'b0);
        end
    endtask

    initial begin
        repeat (10) begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 23;
        rx_idle_pct = 55;

        // Reset settings: the first sample is taken as a change even when high,
        // a high line without an earlier low starts nothing, and a plain
        // pulse passes through unsnapped.
        send_run(1'b1, 3);
        send_pulse(1, 30);
        pause_sender();

        // Small windows: each snap rule and both sides of every exclusive bound.
        // A timeout fires on a flat low line and on a flat high line.
        program_regs(20'd2, 1'b1, 1'b1, 15'd5, 15'd9, 15'd3, 15'd12);
        send_pulse(1, 1);
        send_pulse(1, 2);
        send_pulse(1, 3);
        send_pulse(1, 5);
        send_pulse(1, 6);
        send_pulse(1, 9);
        send_pulse(1, 12);
        send_pulse(1, 13);
        send_run(1'b0, 3);
        send_run(1'b1, 3);
        pause_sender();

        // Widest window and thresholds with the longest timeout: a short pulse
        // and a longer one both snap to center.
        program_regs(spdd_pkg::IDLE_MAX, 1'b1, 1'b1, '0, spdd_pkg::WIDTH_MAX, '0,
                     spdd_pkg::WIDTH_MAX);
        send_pulse(1, 1);
        send_pulse(1, 40);
        pause_sender();

        // Bounds in reverse order: the window is empty, and the upper snap
        // result falls below the lower threshold and is snapped again.
        program_regs(20'd1, 1'b1, 1'b1, spdd_pkg::WIDTH_MAX, '0, spdd_pkg::WIDTH_MAX, '0);
        send_pulse(1, 4);
        send_run(1'b1, 2);
        pause_sender();

        // Snapping off: widths pass through even inside the windows.
        program_regs(20'd3, 1'b0, 1'b0, 15'd5, 15'd9, 15'd3, 15'd12);
        send_pulse(1, 1);
        send_pulse(2, 6);
        send_pulse(1, 13);

        // Random traffic under the three idling patterns. The last phase also
        // holds the receiver off long enough for the block to back up.
        random_phase(23, 55, 1'b0);
        random_phase(55, 23, 1'b0);
        random_phase(0, 0, 1'b1);

        pause_sender();
        $display("Sent %0d pin samples over %0d register settings.",
                 words_sent, settings_used);
        $display("Checked %0d width words and %0d timeout words, %0d mismatches.",
                 width_words, timeout_words, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a millisecond.
    initial begin
        #5_000_000;
        $display("Timed out with %0d words still expected.", pending);
        $display("status: fail");
        $finish;
    end

endmodule
